FILE: hdl/rlps_pkg.sv
// Shared types, codes and constants of the RGB LED PWM blink sequencer.
// No dependencies; the design files refer to this package by scoped names, the test files import it.
package rlps_pkg;

  // Input item function codes
  localparam logic [1:0] FUNC_PWM_TICK = 2'd0;
  localparam logic [1:0] FUNC_SEQ_TICK = 2'd1;
  localparam logic [1:0] FUNC_START    = 2'd2;

  // Colour codes carried by a start item
  localparam logic [1:0] PAT_WHITE     = 2'd0;
  localparam logic [1:0] PAT_RED       = 2'd1;
  localparam logic [1:0] PAT_GREEN     = 2'd2;
  localparam logic [1:0] PAT_STEP_ONLY = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] REG_PWM_PERIOD       = 2'd0;
  localparam logic [1:0] REG_SHORT_STEP_TICKS = 2'd1;
  localparam logic [1:0] REG_LONG_STEP_TICKS  = 2'd2;

  // Configuration reset values
  localparam logic [7:0] PWM_PERIOD_RST       = 8'd100;
  localparam logic [4:0] SHORT_STEP_TICKS_RST = 5'd3;
  localparam logic [4:0] LONG_STEP_TICKS_RST  = 5'd20;

  // Sequencer shape
  localparam logic [3:0] NUM_STEPS = 4'd8;
  localparam logic [3:0] LONG_STEP = 4'd6;

  typedef logic [6:0] duty_t;
  // Index 0 red, 1 green, 2 blue
  typedef duty_t [2:0] rgb_duty_t;

  typedef struct packed {
    logic [1:0] func;
    logic [1:0] pattern;
  } in_item_t;

  typedef struct packed {
    logic       led_red;
    logic       led_green;
    logic       led_blue;
    logic       pwm_running;
    logic       sequence_done;
    logic [3:0] current_step;
  } out_item_t;

  typedef struct packed {
    logic [7:0] pwm_period;
    logic [4:0] short_step_ticks;
    logic [4:0] long_step_ticks;
  } cfg_t;

  // Duty triple of a colour; an out-of-range code wraps to white
  function automatic rgb_duty_t colour_duties(input logic [1:0] colour);
    rgb_duty_t d;
    unique case (colour)
      PAT_RED: begin
        d[0] = 7'd100; d[1] = 7'd8;   d[2] = 7'd0;
      end
      PAT_GREEN: begin
        d[0] = 7'd29;  d[1] = 7'd100; d[2] = 7'd0;
      end
      default: begin
        d[0] = 7'd86;  d[1] = 7'd100; d[2] = 7'd63;
      end
    endcase
    return d;
  endfunction

endpackage

FILE: hdl/rgb_led_pwm_blink_sequencer_unit.sv
// Top level of the RGB LED PWM blink sequencer: input register, result register, config port.
// Depends on rlps_pkg, rlps_cfg_regs and rlps_step_core.
//
// Each item passes the input register, where the state update runs, and then the result register.
// Items follow back to back, one per cycle, while the receiver takes results; the rate is set by
// the state update in rlps_step_core, which every item passes in order. The result register
// holds a result until it is taken while the next item waits in the input register.
// Configuration writes complete at once and apply to items processed after them.
module rgb_led_pwm_blink_sequencer_unit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  rlps_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_ready,
  output rlps_pkg::out_item_t  out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data
);

  rlps_pkg::cfg_t       cfg;
  rlps_pkg::in_item_t   s1_item_r;
  logic                 s1_valid_r;
  rlps_pkg::out_item_t  result;
  rlps_pkg::out_item_t  out_item_r;
  logic                 out_valid_r;
  logic                 fire;

  rlps_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rlps_step_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_item_r),
    .cfg    (cfg),
    .result (result)
  );

  // Advance the held item when the result register is free or being emptied
  assign fire      = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_item_r <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item_r <= result;
    end
  end

  // A processed item always lands in the result register
  a_fire_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed item did not reach the result register");

  // End of sequence reports the final step with PWM off
  a_done_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_item_r.sequence_done) |->
      (out_item_r.current_step == rlps_pkg::NUM_STEPS && !out_item_r.pwm_running))
    else $error("sequence done with wrong step or PWM still on");

endmodule

FILE: hdl/rlps_cfg_regs.sv
// Configuration register file of the blink sequencer: period and step tick counts.
// Depends on rlps_pkg for register indexes, reset values and the cfg_t bundle.
module rlps_cfg_regs (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  output rlps_pkg::cfg_t    cfg
);

  rlps_pkg::cfg_t cfg_r;

  // Always take writes; unknown indexes are dropped
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Update the addressed register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_period       <= rlps_pkg::PWM_PERIOD_RST;
      cfg_r.short_step_ticks <= rlps_pkg::SHORT_STEP_TICKS_RST;
      cfg_r.long_step_ticks  <= rlps_pkg::LONG_STEP_TICKS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rlps_pkg::REG_PWM_PERIOD:       cfg_r.pwm_period       <= cfg_data;
        rlps_pkg::REG_SHORT_STEP_TICKS: cfg_r.short_step_ticks <= cfg_data[4:0];
        rlps_pkg::REG_LONG_STEP_TICKS:  cfg_r.long_step_ticks  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: hdl/rlps_step_core.sv
// PWM and sequencer state with the combinational update for one item.
// Depends on rlps_pkg for codes, the duty table and the item structs.
module rlps_step_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  rlps_pkg::in_item_t   item,
  input  rlps_pkg::cfg_t       cfg,
  output rlps_pkg::out_item_t  result
);

  logic                 enabled_r, enabled_nxt;
  logic [7:0]           counter_r, counter_nxt;
  rlps_pkg::rgb_duty_t  duty_r, duty_nxt;
  logic [2:0]           pins_r, pins_nxt;
  logic [1:0]           colour_r, colour_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [4:0]           tick_r, tick_nxt;
  logic                 running_r, running_nxt;

  logic                 seq_go;
  logic                 done;
  logic [4:0]           limit;
  logic [8:0]           cnt_inc;
  logic [3:0]           step_inc;

  assign cnt_inc = {1'b0, counter_r} + 9'd1;

  // Next state for the item in the input register
  always_comb begin
    enabled_nxt = enabled_r;
    counter_nxt = counter_r;
    duty_nxt    = duty_r;
    pins_nxt    = pins_r;
    colour_nxt  = colour_r;
    step_nxt    = step_r;
    tick_nxt    = tick_r;
    running_nxt = running_r;
    seq_go      = 1'b0;
    done        = 1'b0;
    limit       = '0;
    step_inc    = '0;

    unique case (item.func)
      rlps_pkg::FUNC_PWM_TICK: begin
        if (enabled_r) begin
          for (int i = 0; i < 3; i++) begin
            pins_nxt[i] = ({1'b0, duty_r[i]} > counter_r);
          end
          if (cfg.pwm_period == 8'd0) begin
            counter_nxt = cnt_inc[7:0];
          end else begin
            counter_nxt = (cnt_inc >= {1'b0, cfg.pwm_period}) ? 8'd0 : cnt_inc[7:0];
          end
        end
      end
      rlps_pkg::FUNC_SEQ_TICK: begin
        seq_go = 1'b1;
      end
      rlps_pkg::FUNC_START: begin
        if (item.pattern != rlps_pkg::PAT_STEP_ONLY) begin
          colour_nxt  = item.pattern;
          step_nxt    = 4'd0;
          tick_nxt    = 5'd0;
          running_nxt = 1'b1;
        end
        seq_go = 1'b1;
      end
      default: ;
    endcase

    // Run one sequencer step on the (possibly restarted) state
    if (seq_go && running_nxt) begin
      limit = (step_nxt == rlps_pkg::LONG_STEP) ? cfg.long_step_ticks
                                                : cfg.short_step_ticks;
      step_inc = step_nxt + 4'd1;
      if (tick_nxt == 5'd0) begin
        duty_nxt    = step_nxt[0] ? '0 : rlps_pkg::colour_duties(colour_nxt);
        counter_nxt = 8'd0;
        enabled_nxt = 1'b1;
        tick_nxt    = 5'd1;
      end else if (tick_nxt < limit) begin
        tick_nxt = tick_nxt + 5'd1;
      end else begin
        tick_nxt = 5'd0;
        step_nxt = step_inc;
        if (step_inc >= rlps_pkg::NUM_STEPS) begin
          step_nxt    = rlps_pkg::NUM_STEPS;
          running_nxt = 1'b0;
          duty_nxt    = '0;
          enabled_nxt = 1'b0;
          done        = 1'b1;
        end
      end
    end
  end

  // Result as seen after the update
  always_comb begin
    result.led_red       = pins_nxt[0];
    result.led_green     = pins_nxt[1];
    result.led_blue      = pins_nxt[2];
    result.pwm_running   = enabled_nxt;
    result.sequence_done = done;
    result.current_step  = step_nxt;
  end

  // Commit state when the item leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      counter_r <= '0;
      duty_r    <= '0;
      pins_r    <= '0;
      colour_r  <= rlps_pkg::PAT_WHITE;
      step_r    <= '0;
      tick_r    <= '0;
      running_r <= 1'b0;
    end else if (fire) begin
      enabled_r <= enabled_nxt;
      counter_r <= counter_nxt;
      duty_r    <= duty_nxt;
      pins_r    <= pins_nxt;
      colour_r  <= colour_nxt;
      step_r    <= step_nxt;
      tick_r    <= tick_nxt;
      running_r <= running_nxt;
    end
  end

  // PWM only runs inside a sequence
  a_pwm_needs_seq: assert property (@(posedge clk) disable iff (!rst_n)
    enabled_r |-> running_r)
    else $error("PWM enabled outside a running sequence");

  // A running sequence never sits past its last step
  a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (step_r < rlps_pkg::NUM_STEPS))
    else $error("running sequence with step index out of range");

  // Tick count is only held while running
  a_tick_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_r != 5'd0) |-> running_r)
    else $error("step tick count nonzero while idle");

endmodule

FILE: test/rlps_checker.sv
// Scoreboard for the RGB LED PWM blink sequencer: watches the item, result and config
// channels, predicts each result from its own copy of the state, and compares.
// Depends on rlps_pkg for the item types, codes and reset values.
module rlps_checker
  import rlps_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_ready,
  input  in_item_t   in_item,
  input  logic       out_valid,
  input  logic       out_ready,
  input  out_item_t  out_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow configuration
  logic [7:0] period;
  logic [4:0] short_ticks;
  logic [4:0] long_ticks;

  // Shadow sequencer and PWM state; index 0 red, 1 green, 2 blue
  logic       pwm_on;
  logic [7:0] pwm_cnt;
  logic [6:0] duty [3];
  logic [2:0] pins;
  logic [1:0] colour;
  logic [3:0] step;
  logic [4:0] step_ticks;
  logic       seq_active;

  out_item_t  led_expect_q [$];

  initial begin
    errors  = 0;
    pending = 0;
  end

  // Run one blink step; flag the end of the sequence
  task automatic blink_step(output logic finished);
    logic [4:0] limit;
    finished = 1'b0;
    if (seq_active) begin
      limit = (step == LONG_STEP) ? long_ticks : short_ticks;
      if (step_ticks == 5'd0) begin
        // Load the step's duties: odd steps are dark
        if (step[0]) begin
          duty[0] = 7'd0; duty[1] = 7'd0; duty[2] = 7'd0;
        end else begin
          case (colour)
            PAT_RED: begin
              duty[0] = 7'd100; duty[1] = 7'd8;   duty[2] = 7'd0;
            end
            PAT_GREEN: begin
              duty[0] = 7'd29;  duty[1] = 7'd100; duty[2] = 7'd0;
            end
            default: begin
              duty[0] = 7'd86;  duty[1] = 7'd100; duty[2] = 7'd63;
            end
          endcase
        end
        pwm_cnt    = 8'd0;
        pwm_on     = 1'b1;
        step_ticks = 5'd1;
      end else if (step_ticks < limit) begin
        step_ticks = step_ticks + 5'd1;
      end else begin
        step_ticks = 5'd0;
        step       = step + 4'd1;
        if (step >= NUM_STEPS) begin
          step       = NUM_STEPS;
          seq_active = 1'b0;
          duty[0] = 7'd0; duty[1] = 7'd0; duty[2] = 7'd0;
          pwm_on     = 1'b0;
          finished   = 1'b1;
        end
      end
    end
  endtask

  // Apply one item to the shadow state and form the result it should give
  task automatic predict_leds(input in_item_t it, output out_item_t res);
    logic       finished;
    logic [8:0] nxt;
    finished = 1'b0;
    case (it.func)
      FUNC_PWM_TICK: begin
        if (pwm_on) begin
          for (int i = 0; i < 3; i++) pins[i] = ({1'b0, duty[i]} > pwm_cnt);
          nxt = {1'b0, pwm_cnt} + 9'd1;
          if (period == 8'd0) pwm_cnt = nxt[7:0];
          else pwm_cnt = (nxt >= {1'b0, period}) ? 8'd0 : nxt[7:0];
        end
      end
      FUNC_SEQ_TICK: blink_step(finished);
      FUNC_START: begin
        if (it.pattern != PAT_STEP_ONLY) begin
          colour     = it.pattern;
          step       = 4'd0;
          step_ticks = 5'd0;
          seq_active = 1'b1;
        end
        blink_step(finished);
      end
      default: ;
    endcase
    res.led_red       = pins[0];
    res.led_green     = pins[1];
    res.led_blue      = pins[2];
    res.pwm_running   = pwm_on;
    res.sequence_done = finished;
    res.current_step  = step;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      period      = PWM_PERIOD_RST;
      short_ticks = SHORT_STEP_TICKS_RST;
      long_ticks  = LONG_STEP_TICKS_RST;
      pwm_on      = 1'b0;
      pwm_cnt     = 8'd0;
      for (int i = 0; i < 3; i++) duty[i] = 7'd0;
      pins        = 3'b000;
      colour      = PAT_WHITE;
      step        = 4'd0;
      step_ticks  = 5'd0;
      seq_active  = 1'b0;
      led_expect_q.delete();
    end else begin
      // Compare a taken result with the oldest prediction
      if (out_valid && out_ready) begin
        got = out_item;
        if (led_expect_q.size() == 0) begin
          $error("result with no item outstanding: %h", got);
          errors++;
        end else begin
          want = led_expect_q.pop_front();
          check_field("led_red", want.led_red, got.led_red);
          check_field("led_green", want.led_green, got.led_green);
          check_field("led_blue", want.led_blue, got.led_blue);
          check_field("pwm_running", want.pwm_running, got.pwm_running);
          check_field("sequence_done", want.sequence_done, got.sequence_done);
          check_field("current_step", want.current_step, got.current_step);
        end
      end
      // Track register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PWM_PERIOD:       period      = cfg_data;
          REG_SHORT_STEP_TICKS: short_ticks = cfg_data[4:0];
          REG_LONG_STEP_TICKS:  long_ticks  = cfg_data[4:0];
          default: ;
        endcase
      end
      // Predict each accepted item
      if (in_valid && in_ready) begin
        predict_leds(in_item, want);
        led_expect_q.push_back(want);
      end
    end
    pending <= led_expect_q.size();
  end

endmodule

FILE: test/tb.sv
// Top of the blink sequencer testbench: clock, reset, item and config stimulus, receiver
// stalls, watchdog and verdict. Depends on rlps_pkg, rlps_checker and the unit under test.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rlps_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] REG_UNUSED  = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;
  logic       hold_req = 1'b0;
  int         errors;
  int         pending;
  int         burst_left = 0;
  int         idle_cycles = 0;

  rgb_led_pwm_blink_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rlps_checker scoreboard (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall rate changes every so often; one long hold-off on request
  initial begin
    int mode_left;
    int stall_pct;
    int hold_left;
    bit hold_done;
    mode_left = 0;
    stall_pct = 0;
    hold_left = 0;
    hold_done = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(16, 80);
          case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 30;
            default: stall_pct = 70;
          endcase
        end
        mode_left--;
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  // Offer one item in bursts with random gaps; returns at the accepting edge or after the gap
  task automatic send_item(input logic [1:0] func, input logic [1:0] pattern);
    int gap;
    if (burst_left == 0)
      burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
    in_valid <= 1'b1;
    in_item  <= '{func: func, pattern: pattern};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Drop valid and wait until every predicted result has been taken
  task automatic drain;
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write one register; hold valid when another write follows
  task automatic cfg_write(input logic [1:0] idx, input logic [7:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (!more) cfg_valid <= 1'b0;
  endtask

  // Reconfigure while idle, then run a start followed by random items
  task automatic run_phase(input logic [7:0] per, input logic [4:0] st, input logic [4:0] lt,
                           input int n, input int seq_pct, input bit odd_index, input bit hold);
    int r;
    logic [1:0] pat;
    drain();
    cfg_write(REG_PWM_PERIOD, per, 1);
    cfg_write(REG_SHORT_STEP_TICKS, {3'($urandom), st}, 1);
    cfg_write(REG_LONG_STEP_TICKS, {3'($urandom), lt}, odd_index);
    if (odd_index) cfg_write(REG_UNUSED, 8'($urandom), 0);
    send_item(FUNC_START, 2'($urandom_range(0, 2)));
    for (int k = 1; k < n; k++) begin
      if (hold && k == n / 2) hold_req <= 1'b1;
      r   = $urandom_range(0, 99);
      pat = 2'($urandom);
      if (r < 2) send_item(FUNC_START, pat);
      else if (r < 4) send_item(FUNC_UNUSED, pat);
      else if (r < 4 + seq_pct) send_item(FUNC_SEQ_TICK, pat);
      else send_item(FUNC_PWM_TICK, pat);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Idle sequencer, disabled PWM and the ignored function
    send_item(FUNC_SEQ_TICK, PAT_WHITE);
    send_item(FUNC_START, PAT_STEP_ONLY);
    send_item(FUNC_PWM_TICK, PAT_GREEN);
    send_item(FUNC_UNUSED, PAT_STEP_ONLY);
    // White pattern, then restarts while running
    send_item(FUNC_START, PAT_WHITE);
    repeat (3) send_item(FUNC_PWM_TICK, PAT_WHITE);
    send_item(FUNC_SEQ_TICK, PAT_RED);
    send_item(FUNC_SEQ_TICK, PAT_GREEN);
    send_item(FUNC_PWM_TICK, PAT_STEP_ONLY);
    send_item(FUNC_START, PAT_RED);
    repeat (2) send_item(FUNC_PWM_TICK, PAT_RED);
    // Start with no colour only advances the running sequence
    send_item(FUNC_START, PAT_STEP_ONLY);
    repeat (3) send_item(FUNC_SEQ_TICK, PAT_STEP_ONLY);
    send_item(FUNC_PWM_TICK, PAT_WHITE);
    send_item(FUNC_START, PAT_GREEN);
    send_item(FUNC_PWM_TICK, PAT_GREEN);
    send_item(FUNC_UNUSED, PAT_RED);
    send_item(FUNC_PWM_TICK, PAT_GREEN);

    // Reset settings, then the extremes and a random mix
    run_phase(8'd100, 5'd3, 5'd20, 90, 50, 0, 0);
    run_phase(8'd1, 5'd1, 5'd1, 70, 55, 0, 0);
    run_phase(8'd0, 5'd31, 5'd31, 150, 5, 1, 0);
    run_phase(8'd255, 5'd0, 5'd0, 70, 45, 0, 0);
    run_phase(8'd7, 5'd2, 5'd5, 60, 45, 0, 1);
    run_phase(8'($urandom), 5'($urandom), 5'($urandom), 80, 45, 0, 0);

    drain();
    repeat (10) @(posedge clk);
    if (errors == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
